@@ hdl/mda_pkg.sv @@
package mda_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int ELEM_W   = 12;
    localparam int ADJ_W    = 37;
    localparam int DET_W    = 50;
    localparam int TRACE_W  = 15;
    localparam int CFG_W    = 3;
    localparam int IDX_W    = 2;
    localparam logic [CFG_W-1:0] SIZE_RESET = 3'd4;

    // front-to-back command word
    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
        logic              wr;
        logic              done;
    } mda_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } mda_state_t;

endpackage

@@ hdl/mda_ram.sv @@
module mda_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/mda_front.sv @@
module mda_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [mda_pkg::ELEM_W-1:0] s_element_value,
    input  logic [mda_pkg::IDX_W-1:0]    s_element_row,
    input  logic [mda_pkg::IDX_W-1:0]    s_element_col,
    input  logic                         s_load_done,
    output logic                         q_valid,
    input  logic                         q_ready,
    output mda_pkg::mda_cmd_t            q_cmd
);
    import mda_pkg::*;

    localparam int MAX_ORDER = MAX_ORDER_DEF;
    localparam int QD = 2;

    mda_cmd_t   fifo_reg [QD];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    mda_cmd_t   cmd;
    logic       push, pop;

    // classify: flag elements outside the store as not to be written
    always_comb begin
        cmd.row   = s_element_row;
        cmd.col   = s_element_col;
        cmd.value = s_element_value;
        cmd.wr    = ({1'b0, s_element_row} < 3'(MAX_ORDER))
                    && ({1'b0, s_element_col} < 3'(MAX_ORDER));
        cmd.done  = s_load_done;
    end

    assign s_ready = (cnt_reg != 2'(QD));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = fifo_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            fifo_reg[wp_reg] <= cmd;
        end
    end
endmodule

@@ hdl/mda_back.sv @@
module mda_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mda_pkg::CFG_W-1:0]     size_in_use,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  mda_pkg::mda_cmd_t             q_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [mda_pkg::ADJ_W-1:0]   m_adj_value,
    output logic [mda_pkg::IDX_W-1:0]     m_adj_row,
    output logic [mda_pkg::IDX_W-1:0]     m_adj_col,
    output logic signed [mda_pkg::DET_W-1:0]   m_determinant,
    output logic signed [mda_pkg::TRACE_W-1:0] m_trace_sum,
    output logic                          m_singular,
    output logic                          m_last_result
);
    import mda_pkg::*;

    localparam int MAX_ORDER = MAX_ORDER_DEF;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RAM_D = 1 << AW;
    localparam int P_W   = 2 * ELEM_W + 1;

    // working copy of the matrix, padded to 4x4 with a unit diagonal, loaded from the ram
    logic signed [ELEM_W-1:0] a_reg [4][4];
    logic signed [ADJ_W-1:0]  c3_reg [4][4]; // 3x3 minors (row skip, col skip)
    logic signed [DET_W-1:0]  det_reg;
    logic signed [TRACE_W-1:0] tr_reg;
    logic [2:0] n_reg;

    // first stage of the 3x3 minor
    logic signed [P_W-1:0]    p_reg [3];
    logic signed [ELEM_W-1:0] e_reg [3];
    logic [1:0]               pr_reg, pc_reg;
    logic                     pv_reg;

    mda_state_t st_reg, st_next;
    logic [AW-1:0] ld_reg, ld_next;
    logic          ld_v_reg;
    logic [AW-1:0] ld_d_reg;
    logic [1:0]    mr_reg, mr_next, mc_reg, mc_next;
    logic [1:0]    er_reg, er_next, ec_reg, ec_next;

    logic              ram_we;
    logic [AW-1:0]     ram_wa, ram_ra;
    logic [ELEM_W-1:0] ram_rd;

    mda_ram #(.WIDTH(ELEM_W), .DEPTH(RAM_D)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_wa),
        .wdata(q_cmd.value),
        .raddr(ram_ra),
        .rdata(ram_rd)
    );

    logic [2:0] n_eff;
    always_comb begin
        n_eff = size_in_use;
        if (n_eff == 3'd0) n_eff = 3'd1;
        if ({29'd0, n_eff} > 32'(MAX_ORDER)) n_eff = 3'(MAX_ORDER);
    end

    function automatic logic [AW-1:0] addr_of(input logic [1:0] r, input logic [1:0] c);
        logic [31:0] t;
        t = 32'(r) * 32'(MAX_ORDER) + 32'(c);
        return t[AW-1:0];
    endfunction

    // element of the n x n block, zero outside
    function automatic logic signed [ELEM_W-1:0] el(input logic [2:0] n,
            input logic [1:0] r, input logic [1:0] c,
            input logic signed [ELEM_W-1:0] v);
        return ({1'b0, r} < n && {1'b0, c} < n) ? v : '0;
    endfunction

    assign ram_we  = q_valid && q_ready && q_cmd.wr;
    assign ram_wa  = addr_of(q_cmd.row, q_cmd.col);
    assign ram_ra  = ld_reg;
    assign q_ready = (st_reg == ST_IDLE);

    logic emit_fire;
    assign emit_fire = !m_valid || m_ready;

    logic [AW-1:0] last_addr;
    assign last_addr = AW'(DEPTH - 1);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid && q_cmd.done) st_next = ST_LOAD;
            ST_LOAD: if (ld_v_reg && ld_d_reg == last_addr) st_next = ST_MUL;
            ST_MUL:  st_next = ST_ACC;
            ST_ACC:  if (mr_reg == 2'd3 && mc_reg == 2'd3) st_next = ST_EMIT;
            ST_EMIT: if (emit_fire && er_reg == 2'(n_reg - 3'd1)
                         && ec_reg == 2'(n_reg - 3'd1)) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ld_next = ld_reg;
        mr_next = mr_reg;
        mc_next = mc_reg;
        er_next = er_reg;
        ec_next = ec_reg;
        case (st_reg)
            ST_IDLE: begin
                ld_next = '0;
                mr_next = '0;
                mc_next = '0;
                er_next = '0;
                ec_next = '0;
            end
            ST_LOAD: if (ld_reg != last_addr) ld_next = ld_reg + AW'(1);
            ST_ACC: begin
                mc_next = mc_reg + 2'd1;
                if (mc_reg == 2'd3) mr_next = mr_reg + 2'd1;
            end
            ST_EMIT: if (emit_fire) begin
                ec_next = ec_reg + 2'd1;
                if (ec_reg == 2'(n_reg - 3'd1)) begin
                    ec_next = '0;
                    er_next = er_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            ld_v_reg <= 1'b0;
            pv_reg   <= 1'b0;
            m_valid  <= 1'b0;
        end else begin
            st_reg   <= st_next;
            ld_v_reg <= (st_reg == ST_LOAD) && (ld_reg != ld_d_reg || !ld_v_reg);
            pv_reg   <= (st_reg == ST_ACC);
            if (st_reg == ST_EMIT && emit_fire) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
        ld_reg <= ld_next;
        ld_d_reg <= ld_reg;
        mr_reg <= mr_next;
        mc_reg <= mc_next;
        er_reg <= er_next;
        ec_reg <= ec_next;
    end

    // datapath
    logic [1:0] lr, lc;
    always_comb begin
        lr = 2'(32'(ld_d_reg) / MAX_ORDER);
        lc = 2'(32'(ld_d_reg) % MAX_ORDER);
    end

    // 3x3 minor over the three rows other than mr, columns other than mc:
    // 2x2 minors of the last two columns first, then the column-zero expansion
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic signed [P_W-1:0]   p0, p1, p2;
    logic signed [ADJ_W-1:0] c3v;
    always_comb begin
        int k, j;
        k = 0; j = 0;
        for (int i = 0; i < 3; i++) begin
            rs[i] = '0;
            cs[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (2'(i) != mr_reg && k < 3) begin rs[k] = 2'(i); k++; end
            if (2'(i) != mc_reg && j < 3) begin cs[j] = 2'(i); j++; end
        end
        p0 = P_W'(a_reg[rs[1]][cs[1]] * a_reg[rs[2]][cs[2]]
                - a_reg[rs[1]][cs[2]] * a_reg[rs[2]][cs[1]]);
        p1 = P_W'(a_reg[rs[0]][cs[1]] * a_reg[rs[2]][cs[2]]
                - a_reg[rs[0]][cs[2]] * a_reg[rs[2]][cs[1]]);
        p2 = P_W'(a_reg[rs[0]][cs[1]] * a_reg[rs[1]][cs[2]]
                - a_reg[rs[0]][cs[2]] * a_reg[rs[1]][cs[1]]);
        c3v = ADJ_W'(e_reg[0] * p_reg[0] - e_reg[1] * p_reg[1] + e_reg[2] * p_reg[2]);
    end

    // the zero-padded 4x4 matrix with a unit diagonal beyond n gives the n x n
    // determinant; the working copy pads with ones on that diagonal
    logic signed [DET_W-1:0] det4;
    always_comb begin
        det4 = DET_W'(a_reg[0][0] * c3_reg[0][0]) - DET_W'(a_reg[1][0] * c3_reg[1][0])
             + DET_W'(a_reg[2][0] * c3_reg[2][0]) - DET_W'(a_reg[3][0] * c3_reg[3][0]);
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE) begin
            n_reg <= n_eff;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    a_reg[r][c] <= (r == c) ? ELEM_W'(1) : '0;
            tr_reg <= '0;
        end
        if (st_reg == ST_LOAD && ld_v_reg && {1'b0, lr} < n_reg && {1'b0, lc} < n_reg) begin
            a_reg[lr][lc] <= el(n_reg, lr, lc, ram_rd);
            if (lr == lc) tr_reg <= tr_reg + TRACE_W'(signed'(ram_rd));
        end
        if (st_reg == ST_ACC) begin
            p_reg[0] <= p0;
            p_reg[1] <= p1;
            p_reg[2] <= p2;
            e_reg[0] <= a_reg[rs[0]][cs[0]];
            e_reg[1] <= a_reg[rs[1]][cs[0]];
            e_reg[2] <= a_reg[rs[2]][cs[0]];
            pr_reg   <= mr_reg;
            pc_reg   <= mc_reg;
        end
        // the minor for row 3, column 3 lands during the first result cycle
        if (pv_reg) c3_reg[pr_reg][pc_reg] <= c3v;
        if (st_reg == ST_EMIT && er_reg == 2'd0 && ec_reg == 2'd0) det_reg <= det4;
    end

    // adjugate: adj[r][c] = (-1)^(r+c) minor(c, r) of the n x n block;
    // for the padded matrix, minor of the 4x4 equals that of n x n when c,r < n
    logic signed [DET_W-1:0] det_now;
    logic signed [ADJ_W-1:0] adj_now;
    always_comb begin
        det_now = (er_reg == 2'd0 && ec_reg == 2'd0) ? det4 : det_reg;
        adj_now = c3_reg[ec_reg][er_reg];
        if (er_reg[0] ^ ec_reg[0]) adj_now = -adj_now;
        if (n_reg == 3'd1) adj_now = ADJ_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_EMIT && emit_fire) begin
            m_adj_value   <= adj_now;
            m_adj_row     <= er_reg;
            m_adj_col     <= ec_reg;
            m_determinant <= det_now;
            m_trace_sum   <= tr_reg;
            m_singular    <= (det_now == '0);
            m_last_result <= (er_reg == 2'(n_reg - 3'd1)) && (ec_reg == 2'(n_reg - 3'd1));
        end
    end
endmodule

@@ hdl/matrix_determinant_adjugate.sv @@
// channel   | valid/ready          | payload
// s_        | s_valid / s_ready    | element_value, element_row, element_col, load_done
// m_        | m_valid / m_ready    | adj_value, adj_row, adj_col, determinant, trace_sum,
//           |                      | singular, last_result
// cfg_      | cfg_valid / cfg_ready| size_in_use
// elements load one per cycle while s_ready is high, through a two-entry queue into
// the store ram. the last element starts a run that reads the whole store, passes
// through the MUL state, then forms the 3x3 cofactors one per cycle in a two-stage
// pipe; the n*n results then follow one per cycle unless m_ready stalls. while a run
// is busy the queue takes two more elements and s_ready drops. reset is synchronous;
// the store is not cleared.
module matrix_determinant_adjugate (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [mda_pkg::CFG_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [mda_pkg::ELEM_W-1:0] s_element_value,
    input  logic [mda_pkg::IDX_W-1:0] s_element_row,
    input  logic [mda_pkg::IDX_W-1:0] s_element_col,
    input  logic s_load_done,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [mda_pkg::ADJ_W-1:0] m_adj_value,
    output logic [mda_pkg::IDX_W-1:0] m_adj_row,
    output logic [mda_pkg::IDX_W-1:0] m_adj_col,
    output logic signed [mda_pkg::DET_W-1:0] m_determinant,
    output logic signed [mda_pkg::TRACE_W-1:0] m_trace_sum,
    output logic m_singular,
    output logic m_last_result
);
    import mda_pkg::*;

    logic [CFG_W-1:0] size_reg;
    logic             q_valid, q_ready;
    mda_cmd_t         q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    mda_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_element_value(s_element_value), .s_element_row(s_element_row),
        .s_element_col(s_element_col), .s_load_done(s_load_done),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mda_back u_back (
        .aclk(aclk), .aresetn(aresetn), .size_in_use(size_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_adj_value(m_adj_value), .m_adj_row(m_adj_row), .m_adj_col(m_adj_col),
        .m_determinant(m_determinant), .m_trace_sum(m_trace_sum),
        .m_singular(m_singular), .m_last_result(m_last_result)
    );
endmodule

@@ tb/sv/matrix_determinant_adjugate_tb.sv @@
`timescale 1ns / 1ps

module matrix_determinant_adjugate_tb;
    import mda_pkg::*;

    localparam int ORDER_MAX   = MAX_ORDER_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 80;

    typedef struct {
        logic signed [ADJ_W-1:0]   adj;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [DET_W-1:0]   det;
        logic signed [TRACE_W-1:0] trace;
        logic                      singular;
        logic                      last;
    } adj_entry_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [ELEM_W-1:0] s_element_value;
    logic [IDX_W-1:0] s_element_row;
    logic [IDX_W-1:0] s_element_col;
    logic s_load_done;
    logic m_valid;
    logic m_ready;
    logic signed [ADJ_W-1:0] m_adj_value;
    logic [IDX_W-1:0] m_adj_row;
    logic [IDX_W-1:0] m_adj_col;
    logic signed [DET_W-1:0] m_determinant;
    logic signed [TRACE_W-1:0] m_trace_sum;
    logic m_singular;
    logic m_last_result;

    // mirror of the block's matrix store and order register
    logic signed [ELEM_W-1:0] elem_mirror [ORDER_MAX*ORDER_MAX];
    logic [CFG_W-1:0] order_reg;

    adj_entry_t pending_adj[$];
    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit stall_req   = 1'b0;

    matrix_determinant_adjugate dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .s_element_row   (s_element_row),
        .s_element_col   (s_element_col),
        .s_load_done     (s_load_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_adj_value     (m_adj_value),
        .m_adj_row       (m_adj_row),
        .m_adj_col       (m_adj_col),
        .m_determinant   (m_determinant),
        .m_trace_sum     (m_trace_sum),
        .m_singular      (m_singular),
        .m_last_result   (m_last_result)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int order_of(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > ORDER_MAX) return ORDER_MAX;
        return int'(v);
    endfunction

    function automatic longint el(input int r, input int c);
        return longint'(elem_mirror[r*ORDER_MAX + c]);
    endfunction

    function automatic longint det2(input int r0, input int r1, input int c0, input int c1);
        return el(r0, c0) * el(r1, c1) - el(r1, c0) * el(r0, c1);
    endfunction

    function automatic longint det3(input int rs[4], input int cs[4], input int co);
        return el(rs[0], cs[co]) * det2(rs[1], rs[2], cs[co+1], cs[co+2])
             - el(rs[1], cs[co]) * det2(rs[0], rs[2], cs[co+1], cs[co+2])
             + el(rs[2], cs[co]) * det2(rs[0], rs[1], cs[co+1], cs[co+2]);
    endfunction

    // determinant of the k x k block picked by the row and column lists
    function automatic longint det_of(input int k, input int rs[4], input int cs[4]);
        int sub[4];
        int m;
        longint acc;
        acc = 0;
        case (k)
            0: acc = 1;
            1: acc = el(rs[0], cs[0]);
            2: acc = det2(rs[0], rs[1], cs[0], cs[1]);
            3: acc = det3(rs, cs, 0);
            default: begin
                for (int i = 0; i < 4; i++) begin
                    m = 0;
                    for (int j = 0; j < 4; j++)
                        if (j != i) begin
                            sub[m] = rs[j];
                            m++;
                        end
                    sub[3] = 0;
                    if (i % 2 == 1) acc -= el(rs[i], cs[0]) * det3(sub, cs, 1);
                    else acc += el(rs[i], cs[0]) * det3(sub, cs, 1);
                end
            end
        endcase
        return acc;
    endfunction

    // signed minor with row skip_r and column skip_c removed
    function automatic longint cofactor(input int n, input int skip_r, input int skip_c);
        int rs[4];
        int cs[4];
        int a;
        int b;
        longint v;
        a = 0;
        b = 0;
        rs = '{0, 0, 0, 0};
        cs = '{0, 0, 0, 0};
        for (int i = 0; i < n; i++) begin
            if (i != skip_r) begin
                rs[a] = i;
                a++;
            end
            if (i != skip_c) begin
                cs[b] = i;
                b++;
            end
        end
        v = det_of(n - 1, rs, cs);
        return ((skip_r + skip_c) % 2 == 1) ? -v : v;
    endfunction

    task automatic predict_adjugate();
        int n;
        int idx[4];
        longint det;
        longint tr;
        adj_entry_t e;
        n = order_of(order_reg);
        idx = '{0, 1, 2, 3};
        det = det_of(n, idx, idx);
        tr = 0;
        for (int i = 0; i < n; i++) tr += el(i, i);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                e.adj      = (n == 1) ? ADJ_W'(1) : ADJ_W'(cofactor(n, c, r));
                e.row      = IDX_W'(r);
                e.col      = IDX_W'(c);
                e.det      = DET_W'(det);
                e.trace    = TRACE_W'(tr);
                e.singular = (det == 0);
                e.last     = (r == n - 1) && (c == n - 1);
                pending_adj.push_back(e);
            end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        adj_entry_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_adj.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                e = pending_adj.pop_front();
                if (m_adj_value !== e.adj) report_mismatch("adj_value", m_adj_value, e.adj);
                if (m_adj_row !== e.row) report_mismatch("adj_row", m_adj_row, e.row);
                if (m_adj_col !== e.col) report_mismatch("adj_col", m_adj_col, e.col);
                if (m_determinant !== e.det)
                    report_mismatch("determinant", m_determinant, e.det);
                if (m_trace_sum !== e.trace)
                    report_mismatch("trace_sum", m_trace_sum, e.trace);
                if (m_singular !== e.singular)
                    report_mismatch("singular", m_singular, e.singular);
                if (m_last_result !== e.last)
                    report_mismatch("last_result", m_last_result, e.last);
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver: runs of ready high or low, plus the long hold-off on request
    initial begin
        int run;
        bit level;
        run = 0;
        level = 1'b1;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stall_req) begin
                stall_req = 1'b0;
                stall_left = 400;
                m_ready <= 1'b0;
            end else begin
                if (run == 0) begin
                    level = ($urandom_range(0, 99) < 65);
                    run = level ? $urandom_range(1, 30) : gap_len() + 1;
                end
                run--;
                m_ready <= level;
            end
        end
    end

    task automatic send_element(input logic signed [ELEM_W-1:0] v, input int r, input int c,
                                input bit done, input bit no_gap);
        int gap;
        s_element_value <= v;
        s_element_row   <= IDX_W'(r);
        s_element_col   <= IDX_W'(c);
        s_load_done     <= done;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        elem_mirror[r*ORDER_MAX + c] = v;
        if (done) predict_adjugate();
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_adj.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_order(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        order_reg = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value(input int mode);
        case (mode)
            0: return ELEM_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return -12'sd2048;
                    1: return 12'sd2047;
                    2: return 12'sd0;
                    default: return -12'sd1;
                endcase
            end
            default: return ELEM_W'($urandom_range(0, 4) - 2);
        endcase
    endfunction

    // one n x n matrix in shuffled order, last element marked done
    task automatic load_matrix(input int n, input int mode, input bit no_gap);
        int pos[16];
        logic signed [ELEM_W-1:0] vals[16];
        int t;
        int j;
        int cnt;
        cnt = n * n;
        for (int i = 0; i < cnt; i++) pos[i] = i;
        for (int i = cnt - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pos[i];
            pos[i] = pos[j];
            pos[j] = t;
        end
        // values are chosen in row order before the shuffled sending
        for (int i = 0; i < cnt; i++) begin
            vals[i] = pick_value(mode);
            if (mode == 3 && n > 1 && i / n == 0) vals[i] = pick_value(2);
            // copy of row zero makes the matrix singular
            if (mode == 3 && n > 1 && i / n == 1) vals[i] = vals[i % n];
        end
        for (int i = 0; i < cnt; i++)
            send_element(vals[pos[i]], pos[i] / n, pos[i] % n, i == cnt - 1, no_gap);
    endtask

    task automatic test_full_extremes();
        for (int i = 0; i < 16; i++)
            send_element(((i % 5) == 0) ? -12'sd2048 : 12'sd2047, i / 4, i % 4, i == 15, 1'b0);
        for (int i = 0; i < 4; i++)
            send_element(-12'sd2048, i, i, i == 3, 1'b0);
        send_element(12'sd0, 3, 0, 1'b1, 1'b0);
    endtask

    task automatic test_order_one();
        write_order(3'd1);
        send_element(12'sd5, 2, 3, 1'b0, 1'b0);
        send_element(-12'sd2048, 0, 0, 1'b1, 1'b0);
        send_element(12'sd0, 0, 0, 1'b1, 1'b0);
    endtask

    task automatic test_order_out_of_range();
        write_order(3'd0);
        send_element(12'sd2047, 0, 0, 1'b1, 1'b0);
        write_order(3'd7);
        send_element(12'sd1, 1, 1, 1'b1, 1'b0);
        write_order(3'd5);
        send_element(-12'sd1, 3, 3, 1'b1, 1'b0);
    endtask

    task automatic test_random_matrices();
        int n;
        int p;
        logic [CFG_W-1:0] cfg_choices[8];
        cfg_choices = '{3'd2, 3'd3, 3'd4, 3'd1, 3'd3, 3'd2, 3'd4, 3'd6};
        for (int phase = 0; phase < 8; phase++) begin
            write_order(cfg_choices[phase]);
            n = order_of(cfg_choices[phase]);
            for (int k = 0; k < 6; k++) begin
                p = $urandom_range(0, 9);
                if (p < 7) begin
                    load_matrix(n, $urandom_range(0, 3), 1'b0);
                end else if (p < 9) begin
                    // stray elements, some beyond the order
                    repeat ($urandom_range(1, 4))
                        send_element(pick_value(0), $urandom_range(0, 3),
                                     $urandom_range(0, 3), 1'b0, 1'b0);
                end else begin
                    // broken sequence: done after a partial reload
                    repeat ($urandom_range(0, 3))
                        send_element(pick_value(0), $urandom_range(0, n - 1),
                                     $urandom_range(0, n - 1), 1'b0, 1'b0);
                    send_element(pick_value(1), $urandom_range(0, 3),
                                 $urandom_range(0, 3), 1'b1, 1'b0);
                end
            end
        end
    endtask

    task automatic test_output_stall();
        write_order(3'd4);
        stall_req = 1'b1;
        for (int k = 0; k < 3; k++) load_matrix(4, 0, 1'b1);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_element_value <= '0;
        s_element_row   <= '0;
        s_element_col   <= '0;
        s_load_done     <= 1'b0;
        m_ready   <= 1'b0;
        order_reg = SIZE_RESET;
        for (int i = 0; i < ORDER_MAX*ORDER_MAX; i++) elem_mirror[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(posedge aclk);

        test_full_extremes();
        test_order_one();
        test_order_out_of_range();
        test_random_matrices();
        test_output_stall();

        wait_idle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
